// ----- rtl/hex_escape_decoder_utf8_assert.svh -----
// Assertion macros for the hex escape decoder.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef HEX_ESCAPE_DECODER_UTF8_ASSERT_SVH
`define HEX_ESCAPE_DECODER_UTF8_ASSERT_SVH

// same-cycle implication
`define HEXD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HEXD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hexd_pkg.sv -----
// Shared types for the hex escape decoder.
// No dependencies.
package hexd_pkg;

    // Bytes caused by one input item, first byte in bytes[0].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            eot;
    } t_burst;

endpackage

// ----- rtl/hexd_in_if.sv -----
// Input channel: one UTF-16 code unit per transfer.
// No dependencies.
interface hexd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- rtl/hexd_out_if.sv -----
// Output channel: one decoded byte per transfer.
// No dependencies.
interface hexd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       end_of_text;

    modport source (output valid, output out_byte, output last_in_run,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_byte, input last_in_run,
                    input end_of_text, output ready);
endinterface

// ----- rtl/hexd_front.sv -----
// Front end: accepts code units, tracks escape state, builds byte bursts.
// Depends on hexd_pkg and hexd_in_if.
module hexd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hexd_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output hexd_pkg::t_burst o_burst
);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [15:0] CH_BSLASH  = 16'h005C;
    localparam logic [15:0] CH_X       = 16'h0078;
    localparam logic [7:0]  SUBST_BYTE = 8'h3F;

    logic [1:0]  r_mode, n_mode;
    logic [7:0]  r_acc, n_acc;
    logic [15:0] u;
    logic        last, accept, is_bs, is_x, is_dig, body_v, pre_v, body_on;
    logic [3:0]  dval;
    logic [7:0]  pre_b;
    logic [1:0]  e_cnt;
    logic [7:0]  e0, e1, e2;
    logic [2:0]  total;

    assign u      = i_in.char_code;
    assign last   = i_in.is_last;
    assign accept = i_in.valid && !i_full;
    assign i_in.ready = !i_full;
    assign is_bs  = (u == CH_BSLASH);
    assign is_x   = (u == CH_X);
    assign body_v = !(is_bs && !last);

    always_comb begin
        is_dig = 1'b1;
        dval   = u[3:0];
        if (u inside {[16'h0030:16'h0039]}) begin
            dval = u[3:0];
        end else if (u inside {[16'h0041:16'h0046], [16'h0061:16'h0066]}) begin
            dval = 4'(u[3:0] + 4'd9);
        end else begin
            is_dig = 1'b0;
        end
    end

    always_comb begin
        e0 = u[7:0];
        e1 = 8'h00;
        e2 = 8'h00;
        e_cnt = 2'd1;
        if (u < 16'h0080) begin
            e0 = u[7:0];
        end else if (u < 16'h0800) begin
            e0 = {3'b110, u[10:6]};
            e1 = {2'b10, u[5:0]};
            e_cnt = 2'd2;
        end else if (u[15:11] == 5'b11011) begin
            e0 = SUBST_BYTE;
        end else begin
            e0 = {4'b1110, u[15:12]};
            e1 = {2'b10, u[11:6]};
            e2 = {2'b10, u[5:0]};
            e_cnt = 2'd3;
        end
    end

    always_comb begin
        pre_v   = 1'b0;
        pre_b   = 8'h00;
        body_on = 1'b0;
        n_mode  = MODE_NORMAL;
        n_acc   = r_acc;
        case (r_mode)
            MODE_ESC: begin
                if (is_x) begin
                    n_mode = MODE_HEX;
                    n_acc  = 8'h00;
                    pre_v  = last;
                end else if (is_bs) begin
                    pre_v = 1'b1;
                    pre_b = CH_BSLASH[7:0];
                end else begin
                    pre_v   = 1'b1;
                    pre_b   = CH_BSLASH[7:0];
                    body_on = 1'b1;
                end
            end
            MODE_HEX: begin
                if (is_dig) begin
                    n_acc  = {r_acc[3:0], dval};
                    n_mode = MODE_HEX;
                    pre_v  = last;
                    pre_b  = {r_acc[3:0], dval};
                end else begin
                    pre_v   = 1'b1;
                    pre_b   = r_acc;
                    body_on = body_v;
                    if (is_bs && !last) begin
                        n_mode = MODE_ESC;
                    end
                end
            end
            default: begin
                body_on = body_v;
                if (is_bs && !last) begin
                    n_mode = MODE_ESC;
                end
            end
        endcase
        if (n_mode != MODE_HEX || last) begin
            n_acc = 8'h00;
        end
        if (last) begin
            n_mode = MODE_NORMAL;
        end
    end

    always_comb begin
        total = {2'b00, pre_v} + (body_on ? {1'b0, e_cnt} : 3'd0);
        o_burst.eot = last;
        o_burst.last_idx = 2'(total - 3'd1);
        if (pre_v) begin
            o_burst.bytes[0] = pre_b;
            o_burst.bytes[1] = e0;
            o_burst.bytes[2] = e1;
            o_burst.bytes[3] = e2;
        end else begin
            o_burst.bytes[0] = e0;
            o_burst.bytes[1] = e1;
            o_burst.bytes[2] = e2;
            o_burst.bytes[3] = 8'h00;
        end
    end

    assign o_push = accept && (total != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_acc  <= 8'h00;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule

// ----- rtl/hexd_queue.sv -----
// Burst queue between front end and back end.
// Depends on hexd_pkg.
module hexd_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hexd_pkg::t_burst i_data,
    input  logic             i_pop,
    output hexd_pkg::t_burst o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hexd_pkg::t_burst r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hexd_back.sv -----
// Back end: walks each burst and drives one byte per transfer from a register.
// Depends on hexd_pkg and hexd_out_if.
module hexd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hexd_pkg::t_burst i_head,
    input  logic             i_empty,
    output logic             o_pop,
    hexd_out_if.source       o_out
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_lir, r_eot;
    logic       load, fin;

    assign load  = !i_empty && (!r_valid || o_out.ready);
    assign fin   = (r_idx == i_head.last_idx);
    assign o_pop = load && fin;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_in_run = r_lir;
    assign o_out.end_of_text = r_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= fin ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_lir  <= fin;
            r_eot  <= fin && i_head.eot;
        end
    end

endmodule

// ----- rtl/hex_escape_decoder_utf8.sv -----
// Channel   Dir  Modport  Payload                                 Transfer
// i_in      in   sink     char_code[15:0], is_last                valid && ready
// o_out     out  source   out_byte[7:0], last_in_run, end_of_text valid && ready
//
// Takes one code unit per cycle while the queue is not full; the back end sends one
// byte per cycle while o_out is ready, walking an item of k bytes (0 to 4) in order.
// The burst queue (QUEUE_DEPTH entries) absorbs multi-byte items; input stalls only
// when it is full. Output stalls hold the byte register and back up into the queue.
// Synchronous reset clears escape state, queue pointers and output valid; no sweep.
// Top level of the hex escape decoder; depends on hexd_pkg, the channel interfaces,
// hexd_front, hexd_queue, hexd_back and the assertion macro header.
`include "hex_escape_decoder_utf8_assert.svh"

module hex_escape_decoder_utf8 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hexd_in_if.sink    i_in,
    hexd_out_if.source o_out
);

    hexd_pkg::t_burst w_push_data, w_head;
    logic w_push, w_pop, w_q_full, w_q_empty;

    hexd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_burst (w_push_data)
    );

    hexd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    hexd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_q_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    `HEXD_ASSERT_NOW(a_pop_nonempty, w_pop, !w_q_empty, "pop from empty queue")
    `HEXD_ASSERT_NEXT(a_last_queued, i_in.valid && i_in.ready && i_in.is_last, !w_q_empty, "final unit produced no burst")
    `HEXD_ASSERT_NOW(a_eot_in_run, o_out.valid && o_out.end_of_text, o_out.last_in_run, "end of text off run end")

endmodule
